### rtl/core/bta_pkg.sv
package bta_pkg;

	// heap geometry
	localparam int ARENA_WORDS = 1024;
	localparam int MAX_ARENAS  = 4;
	localparam int WORD_BYTES  = 8;
	localparam int WB_SHIFT    = $clog2(WORD_BYTES);

	localparam int OFF_W   = 10;
	localparam int SLOT_W  = 2;
	localparam int ADDR_W  = SLOT_W + OFF_W;
	localparam int LINK_W  = OFF_W + 1;
	localparam int LIST_W  = 3;
	localparam int STEP_W  = 13;
	localparam int GUARD_W = 11;
	localparam int FREE_W  = 16;
	localparam int NREQ_W  = 15;

	localparam int WALK_LIMIT = 4 * ARENA_WORDS + 8;

	// request codes
	localparam logic [1:0] ACT_ALLOC = 2'd0;
	localparam logic [1:0] ACT_FREE  = 2'd1;
	localparam logic [1:0] ACT_CLEAR = 2'd2;

	// status codes
	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_BAD_PARAM = 2'd1;
	localparam logic [1:0] STAT_NO_ARENA  = 2'd2;
	localparam logic [1:0] STAT_BAD_ADDR  = 2'd3;

	// register map
	typedef enum logic {
		REG_ELEM_BYTES  = 1'b0,
		REG_ARENA_ELEMS = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]       action;
		logic [9:0]       elem_count;
		logic [1:0]       free_arena;
		logic [OFF_W-1:0] free_offset;
	} item_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [SLOT_W-1:0] arena_slot;
		logic [OFF_W-1:0]  data_offset;
	} result_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [LINK_W-1:0] wdata;
		logic [ADDR_W-1:0] raddr;
	} ram_req_t;

	// arena word count, saturated at the arena size
	function automatic logic [OFF_W:0] arena_words(logic [6:0] eb, logic [9:0] ae);
		logic [16:0] bytes;
		logic [14:0] wds;
		logic [15:0] tot;
		bytes = 17'(eb) * 17'(ae);
		wds   = 15'((bytes + 17'(WORD_BYTES - 1)) >> WB_SHIFT);
		tot   = 16'(wds) + 16'd2;
		return (tot > 16'(ARENA_WORDS)) ? (OFF_W+1)'(ARENA_WORDS) : tot[OFF_W:0];
	endfunction

	// header word plus data words rounded up
	function automatic logic [NREQ_W-1:0] req_words(logic [9:0] cnt, logic [6:0] eb);
		logic [16:0] bytes;
		bytes = 17'(cnt) * 17'(eb);
		return NREQ_W'((bytes + 17'(WORD_BYTES - 1)) >> WB_SHIFT) + NREQ_W'(1);
	endfunction

endpackage

### rtl/core/bta_ram.sv
module bta_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port, registered read with write-through on same address
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= (we && (waddr == raddr)) ? wdata : mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/bta_ctrl.sv
module bta_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [6:0]              elem_bytes,
	input  logic [9:0]              arena_elems,
	input  logic                    cfg_wr,
	input  logic                    item_valid,
	output logic                    item_ready,
	input  bta_pkg::item_t          item,
	output logic                    res_valid,
	input  logic                    out_free,
	output bta_pkg::result_t        res,
	output bta_pkg::ram_req_t       ram_req,
	input  logic [bta_pkg::LINK_W-1:0] rdata
);
	import bta_pkg::*;

	typedef enum logic [9:0] {
		ST_INIT   = 10'b0000000001,
		ST_SWEEP  = 10'b0000000010,
		ST_IDLE   = 10'b0000000100,
		ST_PICK   = 10'b0000001000,
		ST_RDCUR  = 10'b0000010000,
		ST_MERGE  = 10'b0000100000,
		ST_SPLIT1 = 10'b0001000000,
		ST_SPLIT2 = 10'b0010000000,
		ST_FREE   = 10'b0100000000,
		ST_DONE   = 10'b1000000000
	} state_t;

	typedef enum logic [1:0] {
		SWK_QUIET = 2'd0,
		SWK_CLEAR = 2'd1,
		SWK_GROW  = 2'd2
	} sweep_kind_t;

	state_t              state_q;
	sweep_kind_t         kind_q;
	logic                clr_pend_q;
	logic [OFF_W-1:0]    sw_cnt_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [OFF_W-1:0]    cur_q;
	logic [OFF_W-1:0]    nxt_q;
	logic [OFF_W-1:0]    n_q;
	logic [OFF_W-1:0]    h_q;
	logic [LIST_W-1:0]   idx_q;
	logic                wrap_q;
	logic [STEP_W-1:0]   steps_q;
	logic [GUARD_W-1:0]  guard_q;
	result_t             res_q;

	logic [FREE_W-1:0]   fw_q     [MAX_ARENAS];
	logic [OFF_W-1:0]    sp_q     [MAX_ARENAS];
	logic [SLOT_W-1:0]   order_q  [MAX_ARENAS];
	logic [MAX_ARENAS-1:0] in_use_q;
	logic [LIST_W-1:0]   len_q;

	logic [OFF_W:0]      w;
	logic [OFF_W-1:0]    wm1;
	logic                rd_used;
	logic [OFF_W-1:0]    rd_link;
	logic [OFF_W:0]      split_pos;
	logic                fit;
	logic                steps_last;
	logic                guard_over;
	logic [SLOT_W-1:0]   pick_s;
	logic                pick_live;
	logic                pick_fits;
	logic [SLOT_W-1:0]   grow_s;
	logic [NREQ_W-1:0]   in_n;
	logic                a_bad;
	logic                f_bad;
	logic                fr_bad;
	logic [FREE_W-1:0]   fw_new;
	logic [LIST_W-1:0]   pos;
	logic                drop;
	logic                take_clr;
	logic                accept;
	logic [LINK_W-1:0]   sweep_val;

	// shared decode
	assign w          = arena_words(elem_bytes, arena_elems);
	assign wm1        = OFF_W'(w - (OFF_W+1)'(1));
	assign rd_used    = rdata[LINK_W-1];
	assign rd_link    = rdata[OFF_W-1:0];
	assign split_pos  = (OFF_W+1)'(cur_q) + (OFF_W+1)'(n_q);
	assign fit        = {1'b0, nxt_q} >= split_pos;
	assign steps_last = steps_q == STEP_W'(WALK_LIMIT - 1);
	assign guard_over = guard_q == GUARD_W'(ARENA_WORDS);
	assign pick_s     = order_q[idx_q[SLOT_W-1:0]];
	assign pick_live  = idx_q < len_q;
	assign pick_fits  = fw_q[pick_s] >= FREE_W'(n_q);
	assign in_n       = req_words(item.elem_count, elem_bytes);
	assign a_bad      = in_n > NREQ_W'(wm1);
	assign f_bad      = !in_use_q[item.free_arena] || (item.free_offset == '0)
	                    || (item.free_offset > wm1);
	assign fr_bad     = !rd_used || (rd_link <= h_q) || (rd_link > wm1);
	assign fw_new     = fw_q[slot_q] + FREE_W'(rd_link - h_q);
	assign drop       = (pos != '0) && (pos < len_q) && (fw_new == FREE_W'(wm1));
	assign take_clr   = clr_pend_q && ((state_q == ST_IDLE)
	                    || ((state_q == ST_SWEEP) && (kind_q == SWK_QUIET)));
	assign item_ready = (state_q == ST_IDLE) && !clr_pend_q && !cfg_wr;
	assign accept     = item_valid && item_ready;
	assign res_valid  = state_q == ST_DONE;
	assign res        = res_q;

	// lowest unused slot and list position of the slot being freed
	always_comb begin
		grow_s = '0;
		for (int i = MAX_ARENAS - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				grow_s = SLOT_W'(i);
			end
		end
		pos = len_q;
		for (int i = MAX_ARENAS - 1; i >= 0; i--) begin
			if ((LIST_W'(i) < len_q) && (order_q[i] == slot_q)) begin
				pos = LIST_W'(i);
			end
		end
	end

	// fresh arena image: free block over the arena, used sentinel at the end
	always_comb begin
		if (sw_cnt_q == '0) begin
			sweep_val = {1'b0, wm1};
		end else if (sw_cnt_q == wm1) begin
			sweep_val = {1'b1, {OFF_W{1'b0}}};
		end else begin
			sweep_val = '0;
		end
	end

	// link memory port
	always_comb begin
		ram_req = '0;
		case (state_q)
			ST_SWEEP: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = {slot_q, sw_cnt_q};
				ram_req.wdata = sweep_val;
			end
			ST_IDLE: begin
				ram_req.raddr = {item.free_arena, item.free_offset - OFF_W'(1)};
			end
			ST_PICK: begin
				ram_req.raddr = {pick_s, sp_q[pick_s]};
			end
			ST_RDCUR: begin
				ram_req.raddr = {slot_q, rd_link};
			end
			ST_MERGE: begin
				ram_req.raddr = {slot_q, rd_link};
				ram_req.we    = !rd_used && !guard_over;
				ram_req.waddr = {slot_q, cur_q};
				ram_req.wdata = rdata;
			end
			ST_SPLIT1: begin
				ram_req.we    = {1'b0, nxt_q} > split_pos;
				ram_req.waddr = {slot_q, split_pos[OFF_W-1:0]};
				ram_req.wdata = {1'b0, nxt_q};
			end
			ST_SPLIT2: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = {slot_q, cur_q};
				ram_req.wdata = {1'b1, split_pos[OFF_W-1:0]};
			end
			ST_FREE: begin
				ram_req.we    = !fr_bad;
				ram_req.waddr = {slot_q, h_q};
				ram_req.wdata = {1'b0, rd_link};
			end
			default: begin
				ram_req = '0;
			end
		endcase
	end

	// pending heap clear after a register write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_pend_q <= 1'b0;
		end else begin
			clr_pend_q <= cfg_wr || (clr_pend_q && !take_clr);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_INIT;
			kind_q   <= SWK_QUIET;
			sw_cnt_q <= '0;
			slot_q   <= '0;
			idx_q    <= '0;
			wrap_q   <= 1'b0;
			steps_q  <= '0;
			guard_q  <= '0;
			in_use_q <= '0;
			len_q    <= '0;
			for (int i = 0; i < MAX_ARENAS; i++) begin
				fw_q[i]    <= '0;
				sp_q[i]    <= '0;
				order_q[i] <= '0;
			end
		end else if (take_clr) begin
			state_q <= ST_INIT;
			kind_q  <= SWK_QUIET;
		end else begin
			case (state_q)
				ST_INIT: begin
					for (int i = 0; i < MAX_ARENAS; i++) begin
						fw_q[i]    <= '0;
						sp_q[i]    <= '0;
						order_q[i] <= '0;
					end
					fw_q[0]  <= FREE_W'(wm1);
					in_use_q <= MAX_ARENAS'(1);
					len_q    <= LIST_W'(1);
					slot_q   <= '0;
					sw_cnt_q <= '0;
					state_q  <= ST_SWEEP;
				end
				ST_SWEEP: begin
					if (sw_cnt_q == wm1) begin
						case (kind_q)
							SWK_CLEAR: begin
								res_q   <= '{status: STAT_OK, arena_slot: '0, data_offset: '0};
								state_q <= ST_DONE;
							end
							SWK_GROW: begin
								state_q <= ST_SPLIT1;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end else begin
						sw_cnt_q <= sw_cnt_q + OFF_W'(1);
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (item.action)
							ACT_ALLOC: begin
								if (a_bad) begin
									res_q   <= '{status: STAT_BAD_PARAM, arena_slot: '0,
									             data_offset: '0};
									state_q <= ST_DONE;
								end else begin
									n_q     <= in_n[OFF_W-1:0];
									idx_q   <= '0;
									state_q <= ST_PICK;
								end
							end
							ACT_FREE: begin
								slot_q <= item.free_arena;
								h_q    <= item.free_offset - OFF_W'(1);
								if (f_bad) begin
									res_q   <= '{status: STAT_BAD_ADDR, arena_slot: '0,
									             data_offset: '0};
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_FREE;
								end
							end
							ACT_CLEAR: begin
								kind_q  <= SWK_CLEAR;
								state_q <= ST_INIT;
							end
							default: begin
								res_q   <= '{status: STAT_BAD_PARAM, arena_slot: '0,
								             data_offset: '0};
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_PICK: begin
					if (pick_live) begin
						if (pick_fits) begin
							slot_q  <= pick_s;
							cur_q   <= sp_q[pick_s];
							wrap_q  <= 1'b0;
							steps_q <= '0;
							state_q <= ST_RDCUR;
						end else begin
							idx_q <= idx_q + LIST_W'(1);
						end
					end else if (len_q < LIST_W'(MAX_ARENAS)) begin
						// enable a new arena and append it to the list
						fw_q[grow_s]              <= FREE_W'(wm1);
						sp_q[grow_s]              <= '0;
						in_use_q[grow_s]          <= 1'b1;
						order_q[len_q[SLOT_W-1:0]] <= grow_s;
						len_q                     <= len_q + LIST_W'(1);
						slot_q                    <= grow_s;
						cur_q                     <= '0;
						nxt_q                     <= wm1;
						sw_cnt_q                  <= '0;
						kind_q                    <= SWK_GROW;
						state_q                   <= ST_SWEEP;
					end else begin
						res_q   <= '{status: STAT_NO_ARENA, arena_slot: '0, data_offset: '0};
						state_q <= ST_DONE;
					end
				end
				ST_RDCUR: begin
					if (!rd_used) begin
						nxt_q   <= rd_link;
						guard_q <= '0;
						state_q <= ST_MERGE;
					end else if (((cur_q > rd_link) && wrap_q) || steps_last) begin
						idx_q   <= idx_q + LIST_W'(1);
						state_q <= ST_PICK;
					end else begin
						wrap_q  <= wrap_q || (cur_q > rd_link);
						steps_q <= steps_q + STEP_W'(1);
						cur_q   <= rd_link;
					end
				end
				ST_MERGE: begin
					if (!rd_used) begin
						// absorb the next free block into the current one
						if (guard_over) begin
							idx_q   <= idx_q + LIST_W'(1);
							state_q <= ST_PICK;
						end else begin
							guard_q <= guard_q + GUARD_W'(1);
							nxt_q   <= rd_link;
						end
					end else begin
						if ((cur_q < sp_q[slot_q]) && (sp_q[slot_q] < nxt_q)) begin
							sp_q[slot_q] <= cur_q;
						end
						if (fit) begin
							state_q <= ST_SPLIT1;
						end else if (((nxt_q > rd_link) && wrap_q) || steps_last) begin
							idx_q   <= idx_q + LIST_W'(1);
							state_q <= ST_PICK;
						end else begin
							wrap_q  <= wrap_q || (nxt_q > rd_link);
							steps_q <= steps_q + STEP_W'(1);
							cur_q   <= rd_link;
							state_q <= ST_RDCUR;
						end
					end
				end
				ST_SPLIT1: begin
					state_q <= ST_SPLIT2;
				end
				ST_SPLIT2: begin
					sp_q[slot_q] <= split_pos[OFF_W-1:0];
					fw_q[slot_q] <= (fw_q[slot_q] >= FREE_W'(n_q))
					                ? fw_q[slot_q] - FREE_W'(n_q) : '0;
					res_q        <= '{status: STAT_OK, arena_slot: slot_q,
					                  data_offset: cur_q + OFF_W'(1)};
					state_q      <= ST_DONE;
				end
				ST_FREE: begin
					if (fr_bad) begin
						res_q <= '{status: STAT_BAD_ADDR, arena_slot: '0, data_offset: '0};
					end else begin
						sp_q[slot_q] <= h_q;
						fw_q[slot_q] <= fw_new;
						if (drop) begin
							// close the gap in the arena list
							for (int i = 0; i < MAX_ARENAS - 1; i++) begin
								if ((LIST_W'(i) >= pos) && (LIST_W'(i + 1) < len_q)) begin
									order_q[i] <= order_q[i + 1];
								end
							end
							len_q            <= len_q - LIST_W'(1);
							in_use_q[slot_q] <= 1'b0;
						end
						res_q <= '{status: STAT_OK, arena_slot: '0, data_offset: '0};
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_INIT;
				end
			endcase
		end
	end

endmodule

### rtl/core/boundary_tag_array_allocator.sv
// A free reads the block header and marks the block free; an allocate looks at arena list
// entries, reads block headers and merges free blocks on the walk (the link memory port
// does one read a cycle), and enabling a new arena first writes all W words of its image.
// A clear rebuilds the heap. One request is in work at a time; the result
// register lets the next request enter while a result waits.
// After reset and after any register write the heap is rebuilt over the W arena words
// (W = arena word count, 129 with reset values) with the input not ready.
module boundary_tag_array_allocator (
	input  logic        clk,
	input  logic        arst_n,
	// request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // elem_count[9:0], free_arena[11:10], free_offset[21:12]
	input  logic [1:0]  s_tuser,  // action[1:0]
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // arena_slot[1:0], data_offset[11:2]
	output logic [1:0]  m_tuser,  // status[1:0]
	// register port
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import bta_pkg::*;

	logic [6:0]        elem_bytes_q;
	logic [9:0]        arena_elems_q;
	logic              cfg_wr;
	reg_idx_t          reg_sel;
	item_t             item;
	result_t           res;
	logic              res_valid;
	logic              out_free;
	ram_req_t          ram_req;
	logic [LINK_W-1:0] rdata;
	logic              m_tvalid_q;
	result_t           m_res_q;

	// register port
	assign pready  = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[2]);
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign prdata  = (reg_sel == REG_ARENA_ELEMS) ? {22'd0, arena_elems_q}
	                                               : {25'd0, elem_bytes_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_bytes_q  <= 7'd8;
			arena_elems_q <= 10'd127;
		end else if (cfg_wr) begin
			case (reg_sel)
				REG_ELEM_BYTES:  elem_bytes_q  <= pwdata[6:0];
				REG_ARENA_ELEMS: arena_elems_q <= pwdata[9:0];
				default:         elem_bytes_q  <= elem_bytes_q;
			endcase
		end
	end

	// request unpack
	assign item.action      = s_tuser;
	assign item.elem_count  = s_tdata[9:0];
	assign item.free_arena  = s_tdata[11:10];
	assign item.free_offset = s_tdata[21:12];

	bta_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.elem_bytes  (elem_bytes_q),
		.arena_elems (arena_elems_q),
		.cfg_wr      (cfg_wr),
		.item_valid  (s_tvalid),
		.item_ready  (s_tready),
		.item        (item),
		.res_valid   (res_valid),
		.out_free    (out_free),
		.res         (res),
		.ram_req     (ram_req),
		.rdata       (rdata)
	);

	bta_ram #(
		.WIDTH (LINK_W),
		.DEPTH (MAX_ARENAS * ARENA_WORDS)
	) u_link_ram (
		.clk   (clk),
		.we    (ram_req.we),
		.waddr (ram_req.waddr),
		.wdata (ram_req.wdata),
		.raddr (ram_req.raddr),
		.rdata (rdata)
	);

	// result register
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_free) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			m_res_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_res_q.status;
	assign m_tdata  = {4'd0, m_res_q.data_offset, m_res_q.arena_slot};

endmodule
